// ===== sv/vfcf_pkg.sv =====
package vfcf_pkg;

	localparam int unsigned SampleW   = 16;
	localparam int unsigned CoefW     = 16;
	localparam int unsigned AccW      = 32;
	localparam int unsigned AccShift  = 15;
	localparam int unsigned InDepth   = 8;
	localparam int unsigned OutDepth  = 4;
	localparam int unsigned NumTaps   = 8;
	localparam int unsigned ModeW     = 8;
	localparam int unsigned ModeFirBit = 5;
	localparam int unsigned CfgIdxW   = 3;
	localparam int unsigned CfgDataW  = 64;

	typedef logic signed [SampleW-1:0] sample_t;
	typedef logic signed [CoefW-1:0] coef_t;
	typedef logic [$clog2(InDepth)-1:0] in_ptr_t;
	typedef logic [$clog2(OutDepth)-1:0] out_ptr_t;
	typedef logic [$clog2(NumTaps)-1:0] tap_t;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_FILTER_MODE       = 3'd0,
		CFG_FIR_TAPS_LOW      = 3'd1,
		CFG_FIR_TAPS_HIGH     = 3'd2,
		CFG_IIR_FORWARD_TAPS  = 3'd3,
		CFG_IIR_FEEDBACK_TAPS = 3'd4
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MAC,
		ST_ACC,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic clear;
		logic mul_en;
		logic acc_en;
	} mac_ctrl_t;

	// Arithmetic shift by AccShift, then clamp to the signed sample range.
	function automatic sample_t saturate(input logic [AccW-1:0] acc);
		logic [AccW-AccShift-1:0] s;
		sample_t r;
		s = acc[AccW-1:AccShift];
		if (s[AccW-AccShift-1] != s[SampleW-1]) begin
			r = s[AccW-AccShift-1] ? {1'b1, {(SampleW-1){1'b0}}} : {1'b0, {(SampleW-1){1'b1}}};
		end else begin
			r = s[SampleW-1:0];
		end
		return r;
	endfunction

endpackage

// ===== sv/vfcf_mac.sv =====
module vfcf_mac (
	input  logic                clk,
	input  vfcf_pkg::mac_ctrl_t ctrl,
	input  vfcf_pkg::coef_t     coef,
	input  vfcf_pkg::sample_t   data,
	output vfcf_pkg::sample_t   result
);

	logic signed [vfcf_pkg::AccW-1:0] product_s1;
	logic [vfcf_pkg::AccW-1:0]        acc_q;

	always_ff @(posedge clk) begin
		if (ctrl.mul_en) begin
			product_s1 <= coef * data;
		end
		if (ctrl.clear) begin
			acc_q <= '0;
		end else if (ctrl.acc_en) begin
			acc_q <= acc_q + vfcf_pkg::AccW'(unsigned'(product_s1));
		end
	end

	assign result = vfcf_pkg::saturate(acc_q);

endmodule

// ===== sv/voice_fir_iir_channel_filter.sv =====
// Per-voice channel filter. Each transfer on the input channel carries one signed 16-bit
// sample and yields exactly one filtered sample on the output channel. A single 16x16
// multiplier with a 32-bit wrapping accumulator walks the eight taps one per cycle, so a
// filtered item passes through accept, eight taps, one accumulate and one finish step;
// its result is registered at the finish step and presented in the cycle after it. Bypass
// mode goes straight from accept to finish.
// The finish cycle waits if a previous result has not yet been taken. Configuration should
// only be written while no item is in flight; restart, taken with an input transfer, clears both histories.
module voice_fir_iir_channel_filter (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [vfcf_pkg::CfgIdxW-1:0]    cfg_index,
	input  logic [vfcf_pkg::CfgDataW-1:0]   cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  vfcf_pkg::sample_t               sample_in,
	input  logic                            restart,
	output logic                            out_valid,
	input  logic                            out_ready,
	output vfcf_pkg::sample_t               sample_out
);

	logic [vfcf_pkg::ModeW-1:0]    filter_mode_q;
	logic [vfcf_pkg::CfgDataW-1:0] fir_taps_low_q;
	logic [vfcf_pkg::CfgDataW-1:0] fir_taps_high_q;
	logic [vfcf_pkg::CfgDataW-1:0] iir_forward_taps_q;
	logic [vfcf_pkg::CfgDataW-1:0] iir_feedback_taps_q;

	vfcf_pkg::sample_t in_hist_q [vfcf_pkg::InDepth];
	vfcf_pkg::sample_t out_hist_q [vfcf_pkg::OutDepth];
	vfcf_pkg::in_ptr_t wp_q;
	vfcf_pkg::tap_t    tap_q;
	vfcf_pkg::state_t  state_q, state_d;
	vfcf_pkg::sample_t sample_q;
	vfcf_pkg::sample_t sample_out_q;
	logic              out_valid_q;

	vfcf_pkg::mac_ctrl_t           mac_ctrl;
	logic [vfcf_pkg::CfgDataW-1:0] coef_bank;
	vfcf_pkg::coef_t               coef;
	vfcf_pkg::sample_t             data;
	vfcf_pkg::in_ptr_t             in_slot;
	vfcf_pkg::sample_t             mac_result;
	vfcf_pkg::sample_t             y;
	logic                          accept;
	logic                          fin_go;
	logic                          out_free;
	logic                          bypass;
	logic                          fir_mode;

	assign bypass   = (filter_mode_q == '0);
	assign fir_mode = filter_mode_q[vfcf_pkg::ModeFirBit];
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_mode_q       <= '0;
			fir_taps_low_q      <= '0;
			fir_taps_high_q     <= '0;
			iir_forward_taps_q  <= '0;
			iir_feedback_taps_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				vfcf_pkg::CFG_FILTER_MODE: begin
					filter_mode_q <= cfg_data[vfcf_pkg::ModeW-1:0];
				end
				vfcf_pkg::CFG_FIR_TAPS_LOW:      fir_taps_low_q      <= cfg_data;
				vfcf_pkg::CFG_FIR_TAPS_HIGH:     fir_taps_high_q     <= cfg_data;
				vfcf_pkg::CFG_IIR_FORWARD_TAPS:  iir_forward_taps_q  <= cfg_data;
				vfcf_pkg::CFG_IIR_FEEDBACK_TAPS: iir_feedback_taps_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Operand select for the current tap. IIR feedback taps read the output ring in
	// fixed reverse order, which is the inverted low bits of the tap number.
	always_comb begin
		in_slot = wp_q - tap_q;
		if (fir_mode) begin
			coef_bank = tap_q[2] ? fir_taps_high_q : fir_taps_low_q;
			data      = in_hist_q[in_slot];
		end else if (!tap_q[2]) begin
			coef_bank = iir_forward_taps_q;
			data      = in_hist_q[in_slot];
		end else begin
			coef_bank = iir_feedback_taps_q;
			data      = out_hist_q[~tap_q[1:0]];
		end
		coef = coef_bank[{tap_q[1:0], 4'd0} +: vfcf_pkg::CoefW];
	end

	vfcf_mac u_mac (
		.clk    (clk),
		.ctrl   (mac_ctrl),
		.coef   (coef),
		.data   (data),
		.result (mac_result)
	);

	assign y = bypass ? sample_q : mac_result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vfcf_pkg::ST_IDLE;
			tap_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == vfcf_pkg::ST_MAC) begin
				tap_q <= tap_q + 1'b1;
			end else begin
				tap_q <= '0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		mac_ctrl = '0;
		in_ready = 1'b0;
		fin_go   = 1'b0;
		unique case (state_q)
			vfcf_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					mac_ctrl.clear = 1'b1;
					state_d = bypass ? vfcf_pkg::ST_FIN : vfcf_pkg::ST_MAC;
				end
			end
			vfcf_pkg::ST_MAC: begin
				mac_ctrl.mul_en = 1'b1;
				// The product of the previous tap lands in the accumulator.
				mac_ctrl.acc_en = (tap_q != '0);
				if (tap_q == vfcf_pkg::tap_t'(vfcf_pkg::NumTaps - 1)) begin
					state_d = vfcf_pkg::ST_ACC;
				end
			end
			vfcf_pkg::ST_ACC: begin
				mac_ctrl.acc_en = 1'b1;
				state_d = vfcf_pkg::ST_FIN;
			end
			vfcf_pkg::ST_FIN: begin
				if (out_free) begin
					fin_go  = 1'b1;
					state_d = vfcf_pkg::ST_IDLE;
				end
			end
			default: state_d = vfcf_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_q <= sample_in;
		end
		if (fin_go) begin
			sample_out_q <= y;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_hist_q  <= '{default: '0};
			out_hist_q <= '{default: '0};
			wp_q       <= '0;
		end else if (accept && restart) begin
			in_hist_q  <= '{default: '0};
			out_hist_q <= '{default: '0};
			wp_q       <= '0;
		end else if (fin_go) begin
			in_hist_q[wp_q] <= sample_q;
			wp_q            <= wp_q + 1'b1;
			if (!bypass && !fir_mode) begin
				out_hist_q[wp_q[$clog2(vfcf_pkg::OutDepth)-1:0]] <= y;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_go) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid  = out_valid_q;
	assign sample_out = sample_out_q;

endmodule

// ===== sv/vfcf_checker.sv =====
module vfcf_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          cfg_we,
	input logic [vfcf_pkg::CfgIdxW-1:0]  cfg_index,
	input logic [vfcf_pkg::CfgDataW-1:0] cfg_data,
	input logic                          in_valid,
	input logic                          in_ready,
	input vfcf_pkg::sample_t             sample_in,
	input logic                          restart,
	input logic                          out_valid,
	input logic                          out_ready,
	input vfcf_pkg::sample_t             sample_out
);

	// A result that is not taken stays put.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(sample_out))
		else $error("output changed while stalled");

	// The block works on one item at a time.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input ready right after a transfer");

	// A new result only appears at the end of an item's work, never the cycle after a transfer.
	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared while the block was idle");

endmodule

bind voice_fir_iir_channel_filter vfcf_checker u_vfcf_checker (.*);
